FILE: rtl/pcm_mix_pkg.sv
//------------------------------------------------------------------------------
// pcm_mix_pkg
// Shared types and constants for the PCM channel mixer.
//------------------------------------------------------------------------------
package pcm_mix_pkg;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_BYTE  = 2'd2;
	localparam logic [1:0] FUNC_FRAME = 2'd3;

	localparam logic [15:0] CH_WINDOW = 16'h0100;
	localparam int          CH_STRIDE = 32;

	localparam logic [4:0] R_BASE_HI = 5'h00;
	localparam logic [4:0] R_BASE_LO = 5'h02;
	localparam logic [4:0] R_LEN_HI  = 5'h04;
	localparam logic [4:0] R_LEN_LO  = 5'h06;
	localparam logic [4:0] R_LOOP_HI = 5'h08;
	localparam logic [4:0] R_LOOP_LO = 5'h0A;
	localparam logic [4:0] R_PITCH   = 5'h0C;
	localparam logic [4:0] R_VOLPAN  = 5'h0E;
	localparam logic [4:0] R_CTRL    = 5'h10;
	localparam logic [4:0] R_STATUS  = 5'h12;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] offset;
		logic [15:0] wdata;
	} pcm_in_t;

	typedef struct packed {
		logic        [15:0] rdata;
		logic signed [15:0] left;
		logic signed [15:0] right;
	} pcm_out_t;

	// per-channel record kept in the channel memory
	typedef struct packed {
		logic [31:0] base;
		logic [31:0] length;
		logic [31:0] loop_pt;
		logic [15:0] pitch;
		logic [31:0] step;
		logic [7:0]  gain;
		logic [7:0]  bal;
		logic [7:0]  ctrl;
		logic        active;
		logic [31:0] phase;
	} chan_t;

	localparam int CHAN_W = $bits(chan_t);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_RD,
		ST_RDW,
		ST_WRW,
		ST_DIV,
		ST_CTRLW,
		ST_FCH,
		ST_FEVAL,
		ST_FB0,
		ST_FB1,
		ST_FB2,
		ST_M1,
		ST_M1D,
		ST_M2,
		ST_M2D,
		ST_PAN,
		ST_PAND,
		ST_ACC,
		ST_OUT
	} st_t;

	// truncating signed division by 255: q = trunc(x/255), |x| < 2^26
	function automatic logic signed [26:0] div255(input logic signed [26:0] x);
		logic [26:0] a;
		logic [53:0] p;
		logic [26:0] q;
		logic [35:0] r;
		begin
			a = x[26] ? 27'(-x) : 27'(x);
			p = 54'(a) * 54'd33686019; // ceil(2^33/255)
			q = 27'(p >> 33);
			r = 36'(a) - 36'(q) * 36'd255;
			if (r[35]) q = q - 27'd1;
			else if (r >= 36'd255) q = q + 27'd1;
			div255 = x[26] ? -$signed(q) : $signed(q);
		end
	endfunction

endpackage

FILE: rtl/pcm_mix_ram.sv
//------------------------------------------------------------------------------
// pcm_mix_ram
// Generic single-port synchronous RAM with registered read.
//------------------------------------------------------------------------------
module pcm_mix_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: rtl/pcm_mix_div.sv
//------------------------------------------------------------------------------
// pcm_mix_div
// Pitch to 16.16 step: (pitch << 16) / rate by reciprocal multiplication,
// result in the cycle after start.
//------------------------------------------------------------------------------
module pcm_mix_div #(
	parameter int SAMPLE_RATE = 44100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] pitch,
	output logic        done,
	output logic [31:0] quot
);
	// exact for numerators below 2^32 with a shift of 32 + clog2(rate)
	localparam int          LG    = $clog2(SAMPLE_RATE);
	localparam int          KSH   = 32 + LG;
	localparam int          SH    = KSH - 16;
	localparam logic [33:0] RECIP = 34'(((64'd1 << KSH) + 64'(SAMPLE_RATE) - 64'd1)
		/ 64'(SAMPLE_RATE));

	logic        busy_q;
	logic [49:0] prod_q;

	assign done = busy_q;
	assign quot = 32'(prod_q >> SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= 50'(pitch) * 50'(RECIP);
		end
	end
endmodule

FILE: rtl/pcm_channel_mixer_apu.sv
//------------------------------------------------------------------------------
// pcm_channel_mixer_apu
// Multichannel PCM playback mixer with a register window and sample store.
// A frame walks the channel memory and fetches each playing channel's sample
// through the byte-wide sample port; with output off it skips the walk. A pitch
// write passes through the step divider. The next item is accepted only once
// the last has left its output step and returned to idle; a waiting result
// stalls only the following item's output step.
// After reset a clearing pass zeroes the sample store and resets the channel
// memory; input is held off.
//------------------------------------------------------------------------------
module pcm_channel_mixer_apu
	import pcm_mix_pkg::*;
#(
	parameter int          CHANNELS    = 8,
	parameter int          RAM_BYTES   = 65536,
	parameter logic [31:0] RAM_BASE    = 32'd0,
	parameter int          SAMPLE_RATE = 44100
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pcm_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output pcm_out_t out_data
);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AW = $clog2(RAM_BYTES);
	localparam int CLR_W = (AW > CW) ? AW : CW;
	localparam logic [32:0] LO33 = 33'(RAM_BASE);
	localparam logic [32:0] HI33 = 33'(RAM_BASE) + 33'(RAM_BYTES);

	st_t st_q, st_d;

	pcm_in_t       req_q;
	logic [CW-1:0] ch_q;
	logic [CLR_W:0] clr_q;
	logic [7:0]    mctl_q, mgain_q;
	chan_t         cr_q;
	logic [31:0]   addr_q;
	logic          valid_s_q;
	logic [7:0]    b0_q;
	logic signed [26:0] s_q, t_q, pl_q, pr_q;
	logic signed [17:0] l_q, r_q;
	logic [15:0]   rd_q;
	pcm_out_t      res_q;
	logic          ov_q;
	logic          out_free;

	// channel memory
	logic          cm_we;
	logic [CW-1:0] cm_addr;
	chan_t         cm_wd, cm_rd;
	pcm_mix_ram #(.WIDTH(CHAN_W), .DEPTH(1 << CW)) u_cmem (
		.clk(clk), .we(cm_we), .addr(cm_addr), .wdata(cm_wd), .rdata(cm_rd)
	);

	// sample memory
	logic          sm_we;
	logic [AW-1:0] sm_addr;
	logic [7:0]    sm_wd, sm_rd;
	pcm_mix_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_smem (
		.clk(clk), .we(sm_we), .addr(sm_addr), .wdata(sm_wd), .rdata(sm_rd)
	);

	logic        dv_start, dv_done;
	logic [31:0] dv_quot;
	pcm_mix_div #(.SAMPLE_RATE(SAMPLE_RATE)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .pitch(req_q.wdata),
		.done(dv_done), .quot(dv_quot)
	);

	// register decode
	logic        in_win;
	logic [15:0] woff;
	logic [4:0]  rsel;
	assign woff   = req_q.offset - CH_WINDOW;
	assign in_win = req_q.offset >= CH_WINDOW &&
		17'(req_q.offset) < 17'(CH_WINDOW) + 17'(CHANNELS * CH_STRIDE);
	assign rsel   = woff[4:0];

	logic [CW-1:0] win_ch;
	assign win_ch = CW'(woff >> 5);

	function automatic logic signed [17:0] clip(input logic signed [27:0] v);
		if (v > 28'sd32767) clip = 18'sd32767;
		else if (v < -28'sd32768) clip = -18'sd32768;
		else clip = 18'(v);
	endfunction

	logic [32:0] a33, a33n;
	assign a33  = {1'b0, addr_q};
	assign a33n = a33 + 33'd1;

	logic [31:0] eff_addr;
	assign eff_addr = 32'(a33 - LO33);

	// end-of-sample check on the record just read
	logic [31:0] fe_pos;
	logic        fe_wrap;
	chan_t       fe_rec;
	assign fe_pos  = cm_rd.phase >> 16;
	assign fe_wrap = fe_pos >= cm_rd.length;

	always_comb begin
		fe_rec = cm_rd;
		if (fe_wrap) fe_rec.phase = cm_rd.loop_pt << 16;
	end

	logic signed [26:0] pan_l, pan_r;
	assign pan_l = div255(pl_q);
	assign pan_r = div255(pr_q);

	assign in_ready  = st_q == ST_IDLE;
	assign out_valid = ov_q;
	assign out_data  = res_q;
	assign out_free  = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLR;
			clr_q   <= '0;
			mctl_q  <= '0;
			mgain_q <= 8'd255;
			ov_q    <= 1'b0;
			ch_q    <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLR) clr_q <= clr_q + (CLR_W + 1)'(1);
			if (st_q == ST_OUT && out_free) ov_q <= 1'b1;
			else if (out_valid && out_ready) ov_q <= 1'b0;
			if (in_valid && in_ready) ch_q <= (in_data.func == FUNC_FRAME) ? '0 : ch_q;
			if (st_q == ST_RD) ch_q <= win_ch;
			if (st_q == ST_ACC || (st_q == ST_FEVAL && st_d == ST_FCH)) ch_q <= ch_q + CW'(1);
			if (st_q == ST_WRW && req_q.offset == 16'h0000) mctl_q <= req_q.wdata[7:0];
			if (st_q == ST_WRW && req_q.offset == 16'h0002) mgain_q <= req_q.wdata[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
			rd_q  <= '0;
			l_q   <= '0;
			r_q   <= '0;
		end
		if (st_q == ST_RDW) cr_q <= cm_rd;
		if (st_q == ST_DIV && dv_done && req_q.wdata != 16'd0) cr_q.step <= dv_quot;
		if (st_q == ST_RDW && req_q.func == FUNC_READ) begin
			if (req_q.offset == 16'h0000) rd_q <= {8'd0, mctl_q};
			else if (req_q.offset == 16'h0002) rd_q <= {8'd0, mgain_q};
			else if (in_win) begin
				case (rsel)
					R_BASE_HI: rd_q <= cm_rd.base[31:16];
					R_BASE_LO: rd_q <= cm_rd.base[15:0];
					R_LEN_HI:  rd_q <= cm_rd.length[31:16];
					R_LEN_LO:  rd_q <= cm_rd.length[15:0];
					R_LOOP_HI: rd_q <= cm_rd.loop_pt[31:16];
					R_LOOP_LO: rd_q <= cm_rd.loop_pt[15:0];
					R_PITCH:   rd_q <= cm_rd.pitch;
					R_VOLPAN:  rd_q <= {cm_rd.gain, cm_rd.bal};
					R_CTRL:    rd_q <= {8'd0, cm_rd.ctrl};
					R_STATUS:  rd_q <= {15'd0, cm_rd.active};
					default:   rd_q <= '0;
				endcase
			end
		end
		if (st_q == ST_FEVAL) begin
			cr_q   <= fe_rec;
			addr_q <= cm_rd.base + (fe_wrap ? cm_rd.loop_pt : fe_pos);
		end
		if (st_q == ST_FB0) begin
			valid_s_q <= a33 >= LO33 && a33 < HI33 &&
				(!cr_q.ctrl[2] || a33n < HI33);
		end
		if (st_q == ST_FB1) b0_q <= sm_rd;
		if (st_q == ST_FB2) begin
			if (!valid_s_q) s_q <= '0;
			else if (cr_q.ctrl[2]) s_q <= 27'($signed({b0_q, sm_rd}));
			else s_q <= 27'(($signed({1'b0, b0_q}) - 27'sd128) * 27'sd256);
		end
		if (st_q == ST_M1) t_q <= 27'(s_q * $signed({1'b0, cr_q.gain}));
		if (st_q == ST_M1D) s_q <= div255(t_q);
		if (st_q == ST_M2) t_q <= 27'(s_q * $signed({1'b0, mgain_q}));
		if (st_q == ST_M2D) s_q <= div255(t_q);
		if (st_q == ST_PAN) begin
			pl_q <= 27'(s_q * (27'sd255 - 27'($signed({1'b0, cr_q.bal}))));
			pr_q <= 27'(s_q * 27'($signed({1'b0, cr_q.bal})));
		end
		if (st_q == ST_PAND) begin
			l_q <= clip(28'(l_q) + 28'(pan_l));
			r_q <= clip(28'(r_q) + 28'(pan_r));
		end
		if (st_q == ST_OUT && out_free) res_q <= {rd_q, l_q[15:0], r_q[15:0]};
	end

	logic ch_last;
	assign ch_last = 32'(ch_q) == 32'(CHANNELS - 1);

	always_comb begin
		chan_t nr;
		st_d     = st_q;
		cm_we    = 1'b0;
		cm_addr  = ch_q;
		cm_wd    = cr_q;
		sm_we    = 1'b0;
		sm_addr  = addr_q[AW-1:0] - AW'(RAM_BASE);
		sm_wd    = req_q.wdata[7:0];
		dv_start = 1'b0;
		nr       = cr_q;
		case (st_q)
			ST_CLR: begin
				sm_we   = 1'b1;
				sm_addr = clr_q[AW-1:0];
				sm_wd   = '0;
				cm_we   = 32'(clr_q) < CHANNELS;
				cm_addr = clr_q[CW-1:0];
				cm_wd   = '0;
				cm_wd.pitch = 16'(SAMPLE_RATE);
				cm_wd.gain  = 8'd255;
				cm_wd.bal   = 8'd128;
				if (clr_q[CLR_W]) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					case (in_data.func)
						FUNC_BYTE:  st_d = ST_OUT;
						FUNC_FRAME: st_d = ST_FCH;
						default:    st_d = ST_RD;
					endcase
					if (in_data.func == FUNC_BYTE && 17'(in_data.offset) < 17'(RAM_BYTES)) begin
						sm_we   = 1'b1;
						sm_addr = AW'(in_data.offset);
						sm_wd   = in_data.wdata[7:0];
					end
				end
			end
			ST_RD: begin
				cm_addr = win_ch;
				st_d = ST_RDW;
			end
			ST_RDW: begin
				st_d = (req_q.func == FUNC_WRITE) ? ST_WRW : ST_OUT;
			end
			ST_WRW: begin
				st_d = ST_OUT;
				if (in_win) begin
					cm_we = 1'b1;
					case (rsel)
						R_BASE_HI: nr.base[31:16]    = req_q.wdata;
						R_BASE_LO: nr.base[15:0]     = req_q.wdata;
						R_LEN_HI:  nr.length[31:16]  = req_q.wdata;
						R_LEN_LO:  nr.length[15:0]   = req_q.wdata;
						R_LOOP_HI: nr.loop_pt[31:16] = req_q.wdata;
						R_LOOP_LO: nr.loop_pt[15:0]  = req_q.wdata;
						R_PITCH: begin
							cm_we    = 1'b0;
							dv_start = 1'b1;
							st_d     = ST_DIV;
						end
						R_VOLPAN: begin
							nr.gain = req_q.wdata[15:8];
							nr.bal  = req_q.wdata[7:0];
						end
						R_CTRL: begin
							nr.ctrl = req_q.wdata[7:0];
							if (req_q.wdata[0]) begin
								if (!cr_q.active) begin
									nr.phase  = '0;
									nr.active = 1'b1;
								end
							end else begin
								nr.active = 1'b0;
							end
						end
						default: cm_we = 1'b0;
					endcase
					cm_wd = nr;
				end
			end
			ST_DIV: begin
				if (dv_done) st_d = ST_CTRLW;
			end
			ST_CTRLW: begin
				cm_we = 1'b1;
				cm_wd = cr_q;
				cm_wd.pitch = req_q.wdata;
				st_d = ST_OUT;
			end
			ST_FCH: begin
				st_d = mctl_q[0] ? ST_FEVAL : ST_OUT;
			end
			ST_FEVAL: begin
				if (!cm_rd.ctrl[0] || !cm_rd.active || cm_rd.length == '0) begin
					st_d = ch_last ? ST_OUT : ST_FCH;
				end else if (fe_wrap && !cm_rd.ctrl[1]) begin
					cm_we = 1'b1;
					cm_wd = cm_rd;
					cm_wd.ctrl[0] = 1'b0;
					cm_wd.active  = 1'b0;
					st_d = ch_last ? ST_OUT : ST_FCH;
				end else begin
					st_d = ST_FB0;
				end
			end
			ST_FB0: begin
				sm_addr = eff_addr[AW-1:0];
				st_d = ST_FB1;
			end
			ST_FB1: begin
				sm_addr = AW'(eff_addr + 32'd1);
				st_d = ST_FB2;
			end
			ST_FB2:  st_d = ST_M1;
			ST_M1:   st_d = ST_M1D;
			ST_M1D:  st_d = ST_M2;
			ST_M2:   st_d = ST_M2D;
			ST_M2D:  st_d = ST_PAN;
			ST_PAN:  st_d = ST_PAND;
			ST_PAND: begin
				cm_we = 1'b1;
				cm_wd = cr_q;
				cm_wd.phase = cr_q.phase + cr_q.step;
				st_d = ST_ACC;
			end
			ST_ACC: begin
				st_d = ch_last ? ST_OUT : ST_FCH;
			end
			ST_OUT:  st_d = out_free ? ST_IDLE : ST_OUT;
			default: st_d = ST_IDLE;
		endcase
	end
endmodule

FILE: tb/sv/tb_pcm_channel_mixer_apu.sv
//------------------------------------------------------------------------------
// tb_pcm_channel_mixer_apu
// Drives register reads and writes, sample store writes and frame requests
// into the mixer and checks every result against an internal predictor of
// the register file, channel playback state and saturating stereo mix.
//------------------------------------------------------------------------------
module tb_pcm_channel_mixer_apu
	import pcm_mix_pkg::*;
();

	localparam int NCH   = 8;
	localparam int SBYTES = 65536;
	localparam int SRATE = 44100;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	pcm_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	pcm_out_t out_data;

	pcm_channel_mixer_apu dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #2 clk = ~clk;

	// predicted state
	logic [7:0]  m_ctrl, m_gain;
	logic [31:0] c_base[NCH], c_len[NCH], c_loop[NCH], c_step[NCH], c_phase[NCH];
	logic [15:0] c_pitch[NCH];
	logic [7:0]  c_gain[NCH], c_bal[NCH], c_ctrl[NCH];
	logic        c_act[NCH];
	logic [7:0]  smem[SBYTES];

	pcm_out_t expected_q[$];
	int errors = 0;
	int gap_max = 3;
	bit long_hold = 0;

	function automatic int tdiv(input int x);
		return x / 255;
	endfunction

	function automatic int fetch(input logic [31:0] addr, input bit wide);
		logic [15:0] v;
		if (addr >= SBYTES) return 0;
		if (wide) begin
			if (addr + 1 >= SBYTES) return 0;
			v = {smem[addr], smem[addr + 1]};
			return int'($signed(v));
		end
		return (int'(smem[addr]) - 128) * 256;
	endfunction

	function automatic int clip(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic pcm_out_t predict_mixer(input pcm_in_t it);
		pcm_out_t o;
		int c, r, s, l, rr;
		logic [31:0] pos;
		o = '0;
		case (it.func)
			FUNC_READ: begin
				if (it.offset == 16'h0) o.rdata = m_ctrl;
				else if (it.offset == 16'h2) o.rdata = m_gain;
				else if (it.offset >= CH_WINDOW && it.offset < CH_WINDOW + NCH * CH_STRIDE) begin
					c = (it.offset - CH_WINDOW) / CH_STRIDE;
					r = (it.offset - CH_WINDOW) % CH_STRIDE;
					case (5'(r))
						R_BASE_HI: o.rdata = c_base[c][31:16];
						R_BASE_LO: o.rdata = c_base[c][15:0];
						R_LEN_HI:  o.rdata = c_len[c][31:16];
						R_LEN_LO:  o.rdata = c_len[c][15:0];
						R_LOOP_HI: o.rdata = c_loop[c][31:16];
						R_LOOP_LO: o.rdata = c_loop[c][15:0];
						R_PITCH:   o.rdata = c_pitch[c];
						R_VOLPAN:  o.rdata = {c_gain[c], c_bal[c]};
						R_CTRL:    o.rdata = c_ctrl[c];
						R_STATUS:  o.rdata = c_act[c];
						default:   o.rdata = '0;
					endcase
				end
			end
			FUNC_WRITE: begin
				if (it.offset == 16'h0) m_ctrl = it.wdata[7:0];
				else if (it.offset == 16'h2) m_gain = it.wdata[7:0];
				else if (it.offset >= CH_WINDOW && it.offset < CH_WINDOW + NCH * CH_STRIDE) begin
					c = (it.offset - CH_WINDOW) / CH_STRIDE;
					r = (it.offset - CH_WINDOW) % CH_STRIDE;
					case (5'(r))
						R_BASE_HI: c_base[c][31:16] = it.wdata;
						R_BASE_LO: c_base[c][15:0] = it.wdata;
						R_LEN_HI:  c_len[c][31:16] = it.wdata;
						R_LEN_LO:  c_len[c][15:0] = it.wdata;
						R_LOOP_HI: c_loop[c][31:16] = it.wdata;
						R_LOOP_LO: c_loop[c][15:0] = it.wdata;
						R_PITCH: begin
							c_pitch[c] = it.wdata;
							if (it.wdata != 0) c_step[c] = ({16'h0, it.wdata} << 16) / SRATE;
						end
						R_VOLPAN: begin
							c_gain[c] = it.wdata[15:8];
							c_bal[c] = it.wdata[7:0];
						end
						R_CTRL: begin
							c_ctrl[c] = it.wdata[7:0];
							if (it.wdata[0]) begin
								if (!c_act[c]) begin
									c_phase[c] = '0;
									c_act[c] = 1'b1;
								end
							end else c_act[c] = 1'b0;
						end
						default: ;
					endcase
				end
			end
			FUNC_BYTE: smem[it.offset] = it.wdata[7:0];
			default: begin
				l = 0;
				rr = 0;
				if (m_ctrl[0]) begin
					for (c = 0; c < NCH; c++) begin
						if (!c_ctrl[c][0] || !c_act[c] || c_len[c] == 0) continue;
						pos = c_phase[c] >> 16;
						if (pos >= c_len[c]) begin
							if (c_ctrl[c][1]) begin
								c_phase[c] = c_loop[c] << 16;
								pos = c_loop[c];
							end else begin
								c_ctrl[c][0] = 1'b0;
								c_act[c] = 1'b0;
								continue;
							end
						end
						s = fetch(c_base[c] + pos, c_ctrl[c][2]);
						s = tdiv(s * int'(c_gain[c]));
						s = tdiv(s * int'(m_gain));
						l = clip(l + tdiv(s * (255 - int'(c_bal[c]))));
						rr = clip(rr + tdiv(s * int'(c_bal[c])));
						c_phase[c] = c_phase[c] + c_step[c];
					end
				end
				o.left = 16'(l);
				o.right = 16'(rr);
			end
		endcase
		return o;
	endfunction

	task automatic send_item(input logic [1:0] f, input logic [15:0] off, input logic [15:0] wd);
		pcm_in_t it;
		int g;
		it.func = f;
		it.offset = off;
		it.wdata = wd;
		g = $urandom_range(0, 3) == 0 ? $urandom_range(0, gap_max) : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(predict_mixer(it));
	endtask

	function automatic logic [15:0] chreg(input int c, input logic [4:0] r);
		return CH_WINDOW + 16'(c * CH_STRIDE) + 16'(r);
	endfunction

	task automatic set_chan(input int c, input logic [31:0] base, input logic [31:0] len,
			input logic [31:0] lp, input logic [15:0] pitch, input logic [15:0] vp,
			input logic [7:0] ctl);
		send_item(FUNC_WRITE, chreg(c, R_BASE_HI), base[31:16]);
		send_item(FUNC_WRITE, chreg(c, R_BASE_LO), base[15:0]);
		send_item(FUNC_WRITE, chreg(c, R_LEN_HI), len[31:16]);
		send_item(FUNC_WRITE, chreg(c, R_LEN_LO), len[15:0]);
		send_item(FUNC_WRITE, chreg(c, R_LOOP_HI), lp[31:16]);
		send_item(FUNC_WRITE, chreg(c, R_LOOP_LO), lp[15:0]);
		send_item(FUNC_WRITE, chreg(c, R_PITCH), pitch);
		send_item(FUNC_WRITE, chreg(c, R_VOLPAN), vp);
		send_item(FUNC_WRITE, chreg(c, R_CTRL), 16'(ctl));
	endtask

	task automatic test_directed;
		send_item(FUNC_READ, 16'h0002, 16'h0);
		send_item(FUNC_READ, chreg(NCH - 1, R_PITCH), 16'h0);
		send_item(FUNC_READ, 16'hFFFF, 16'hFFFF);
		send_item(FUNC_WRITE, chreg(0, R_STATUS), 16'hFFFF);
		send_item(FUNC_WRITE, 16'h0101, 16'hFFFF);
		send_item(FUNC_FRAME, 16'h0, 16'h0);
		send_item(FUNC_BYTE, 16'h0000, 16'h00FF);
		send_item(FUNC_BYTE, 16'hFFFF, 16'hFF7F);
		send_item(FUNC_BYTE, 16'hFFFE, 16'h0080);
		send_item(FUNC_WRITE, 16'h0000, 16'hFFFF);
		send_item(FUNC_WRITE, chreg(0, R_PITCH), 16'h0);
		send_item(FUNC_READ, chreg(0, R_PITCH), 16'h0);
		set_chan(0, 32'h0, 32'h2, 32'h0, 16'hFFFF, 16'hFF00, 8'h03);
		set_chan(1, 32'h0000FFFE, 32'h3, 32'h0, 16'd44100, 16'hFFFF, 8'h05);
		repeat (6) send_item(FUNC_FRAME, 16'h0, 16'h0);
		send_item(FUNC_READ, chreg(1, R_STATUS), 16'h0);
	endtask

	task automatic test_playback;
		int c, k, n;
		for (k = 0; k < 30; k++) begin
			n = $urandom_range(1, 12);
			repeat (n) send_item(FUNC_BYTE, 16'($urandom_range(0, 255)), 16'($urandom));
			c = $urandom_range(0, NCH - 1);
			set_chan(c, $urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 250)),
				$urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 6)),
				$urandom_range(0, 9) == 0 ? $urandom : 32'($urandom_range(0, 4)),
				16'($urandom), 16'($urandom), 8'($urandom));
			if ($urandom_range(0, 3) == 0)
				send_item(FUNC_WRITE, 16'h0002, 16'($urandom));
			if ($urandom_range(0, 9) == 0)
				send_item(FUNC_WRITE, 16'h0000, 16'($urandom));
			n = $urandom_range(1, 10);
			repeat (n) send_item(FUNC_FRAME, 16'($urandom), 16'($urandom));
			if ($urandom_range(0, 1))
				send_item(FUNC_READ, chreg(c, 5'($urandom_range(0, 10) * 2)), 16'h0);
		end
	endtask

	task automatic test_noise;
		int k;
		for (k = 0; k < 500; k++)
			send_item(2'($urandom), $urandom_range(0, 3) == 0 ? 16'($urandom)
				: 16'($urandom_range(0, 16'h01FF)), 16'($urandom));
	endtask

	task automatic test_backpressure;
		long_hold = 1;
		gap_max = 0;
		repeat (30) send_item(FUNC_FRAME, 16'h0, 16'h0);
		gap_max = 3;
	endtask

	always @(posedge clk) begin
		if (!long_hold) out_ready <= ($urandom_range(0, 4) != 0);
	end

	initial begin
		wait (long_hold);
		@(posedge clk);
		out_ready <= 1'b0;
		repeat (400) @(posedge clk);
		long_hold = 0;
	end

	always @(posedge clk) begin
		pcm_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (e.rdata !== out_data.rdata || e.left !== out_data.left
						|| e.right !== out_data.right) begin
					$display("%0t: mismatch expected %h/%h/%h actual %h/%h/%h", $time,
						e.rdata, e.left, e.right,
						out_data.rdata, out_data.left, out_data.right);
					errors++;
				end
			end
		end
	end

	initial begin
		int k;
		m_ctrl = '0;
		m_gain = 8'd255;
		for (k = 0; k < NCH; k++) begin
			c_base[k] = '0; c_len[k] = '0; c_loop[k] = '0; c_step[k] = '0;
			c_phase[k] = '0; c_pitch[k] = 16'(SRATE); c_gain[k] = 8'd255;
			c_bal[k] = 8'd128; c_ctrl[k] = '0; c_act[k] = 1'b0;
		end
		for (k = 0; k < SBYTES; k++) smem[k] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_playback();
		test_backpressure();
		test_noise();
		test_playback();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
